// ===== src/qse_pkg.sv =====
// ----------------------------------------------------------------------------
// qse_pkg
// shared types, character codes and helper functions of the string escaper
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int MaxChars = 6;

    localparam logic [6:0] ChQuote  = 7'h22;
    localparam logic [6:0] ChBslash = 7'h5c;
    localparam logic [6:0] ChX      = 7'h78;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic       final_byte;
        logic       empty_text;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       text_done;
        logic       run_end;
    } out_item_t;

    // one classified input byte: its characters, how many, closing quote flag
    typedef struct packed {
        logic [MaxChars-1:0][6:0] chars;
        logic [2:0]               cnt;
        logic                     done;
    } desc_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] res;
        if (nib < 4'd10)
        begin
            res = 7'h30 + {3'b000, nib};
        end
        else
        begin
            res = 7'h57 + {3'b000, nib};
        end
        return res;
    endfunction

    // letter after the backslash for short escapes, zero when none applies
    function automatic logic [6:0] short_escape(input logic [7:0] b);
        logic [6:0] res;
        case (b)
            8'h5c:   res = ChBslash;
            8'h22:   res = ChQuote;
            8'h08:   res = 7'h62;
            8'h0c:   res = 7'h66;
            8'h0a:   res = 7'h6e;
            8'h0d:   res = 7'h72;
            8'h09:   res = 7'h74;
            8'h0b:   res = 7'h76;
            default: res = 7'h00;
        endcase
        return res;
    endfunction

endpackage

// ===== src/qse_front.sv =====
// ----------------------------------------------------------------------------
// qse_front
// classifies one input byte into the list of characters it expands to
// ----------------------------------------------------------------------------
module qse_front (
    input  qse_pkg::in_item_t item,
    input  logic              push,
    input  logic              queue_full,
    output logic              wr_en,
    output qse_pkg::desc_t    wr_data
);
    import qse_pkg::*;

    logic [3:0][6:0] body;
    logic [2:0]      blen;
    logic [6:0]      esc;
    logic [2:0]      off;
    logic [2:0]      k;

    assign wr_en = push && !queue_full;
    assign esc   = short_escape(item.text_byte);
    assign off   = {2'b00, item.first_byte};

    always_comb
    begin
        body = {4{ChQuote}};
        if (esc != 7'h00)
        begin
            body[0] = ChBslash;
            body[1] = esc;
            blen    = 3'd2;
        end
        else if (!(item.text_byte inside {[8'h20:8'h7e]}))
        begin
            body[0] = ChBslash;
            body[1] = ChX;
            body[2] = hex_char(item.text_byte[7:4]);
            body[3] = hex_char(item.text_byte[3:0]);
            blen    = 3'd4;
        end
        else
        begin
            body[0] = item.text_byte[6:0];
            blen    = 3'd1;
        end
    end

    always_comb
    begin
        wr_data = '0;
        k       = '0;
        if (item.empty_text)
        begin
            wr_data.chars[0] = ChQuote;
            wr_data.chars[1] = ChQuote;
            wr_data.cnt      = 3'd2;
            wr_data.done     = 1'b1;
        end
        else
        begin
            for (int i = 0; i < MaxChars; i++)
            begin
                if (3'(i) < off)
                begin
                    wr_data.chars[i] = ChQuote;
                end
                else
                begin
                    k = 3'(i) - off;
                    if (k < blen)
                    begin
                        wr_data.chars[i] = body[k[1:0]];
                    end
                    else
                    begin
                        wr_data.chars[i] = ChQuote;
                    end
                end
            end
            wr_data.cnt  = off + blen + {2'b00, item.final_byte};
            wr_data.done = item.final_byte;
        end
    end

endmodule

// ===== src/qse_fifo.sv =====
// ----------------------------------------------------------------------------
// qse_fifo
// short queue of classified bytes between the front and the back
// ----------------------------------------------------------------------------
module qse_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  qse_pkg::desc_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output qse_pkg::desc_t rd_data,
    output logic           empty
);
    import qse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/qse_back.sv =====
// ----------------------------------------------------------------------------
// qse_back
// walks the head entry one character per cycle into the output register while it is empty or popped
// ----------------------------------------------------------------------------
module qse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  qse_pkg::desc_t      head,
    input  logic                queue_empty,
    output logic                rd_en,
    output logic                empty,
    input  logic                pop,
    output qse_pkg::out_item_t  result
);
    import qse_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    out_item_t  result_reg, result_next;
    logic       adv;
    logic       last_char;

    assign empty     = !valid_reg;
    assign result    = result_reg;
    assign adv       = !queue_empty && (!valid_reg || pop);
    assign last_char = (idx_reg == head.cnt - 3'd1);
    assign rd_en     = adv && last_char;

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        if (adv)
        begin
            valid_next            = 1'b1;
            result_next.out_char  = head.chars[idx_reg];
            result_next.text_done = head.done && last_char;
            result_next.run_end   = last_char;
            idx_next              = last_char ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== src/quoted_string_escaper_core.sv =====
// ----------------------------------------------------------------------------
// quoted_string_escaper_core
// byte stream to double-quoted escaped ascii string literal
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the internal queue has room. Each
// byte becomes one to six output characters, sent one per cycle while the
// output is empty or popped, from a registered output stage; plain printable
// bytes sustain one byte per cycle while each result is popped as it shows. The
// classifier and the serializer are parted by a queue of DEPTH entries, so
// new bytes keep being taken while an escape sequence is being sent, until
// the queue fills, and a result may sit on the output while new bytes are
// taken. The first character of a transaction passes through the queue and
// then the registered output stage before it shows on the result ports.
module quoted_string_escaper_core #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  qse_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output qse_pkg::out_item_t result
);
    import qse_pkg::*;

    logic  wr_en;
    desc_t wr_data;
    logic  rd_en;
    desc_t rd_data;
    logic  queue_empty;

    qse_front u_front (
        .item       (item),
        .push       (push),
        .queue_full (full),
        .wr_en      (wr_en),
        .wr_data    (wr_data)
    );

    qse_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .full    (full),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .empty   (queue_empty)
    );

    qse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (rd_data),
        .queue_empty (queue_empty),
        .rd_en       (rd_en),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

// ===== src/qse_checker.sv =====
// ----------------------------------------------------------------------------
// qse_checker
// port-level checks of the string escaper, bound to the top level
// ----------------------------------------------------------------------------
module qse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input qse_pkg::out_item_t result
);
    import qse_pkg::*;

    // closing quote always ends the run of its transaction
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.text_done |-> result.run_end)
        else $error("text_done without run_end");

    a_done_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.text_done |-> result.out_char == ChQuote)
        else $error("text_done on a character other than a quote");

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.out_char >= 7'h20 && result.out_char <= 7'h7e)
        else $error("non-printable output character");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("stalled result changed");

endmodule

bind quoted_string_escaper_core qse_checker u_qse_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
